### sv/qph_pkg.sv
// Shared types and constants for the quadratic-probe hash table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package qph_pkg;

  localparam int KEY_W    = 32;
  localparam int OPC_W    = 1;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // opcodes
  localparam logic [OPC_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPC_W-1:0] OP_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

  // home slot reduction: key bits consumed per step
  localparam int HOME_BITS  = 2;
  localparam int HOME_STEPS = KEY_W / HOME_BITS;
  localparam int HCNT_W     = $clog2(HOME_STEPS);

  typedef struct packed {
    logic clear;      // write zero at clear pointer
    logic load;       // capture incoming item
    logic home_step;  // one step of key mod TABLE_SIZE
    logic zero_res;   // set zero-key result
    logic probe;      // probe pipeline active
    logic out_load;   // move result into output register
  } qph_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic key_zero;
    logic home_last;
    logic probe_done;
    logic out_free;
  } qph_sts_t;

endpackage

### sv/qph_in_if.sv
// Request channel interface: valid/ready plus opcode and key.
// Depends on qph_pkg for field widths.
interface qph_in_if;
  logic                        valid;
  logic                        ready;
  logic [qph_pkg::OPC_W-1:0]   opcode;
  logic [qph_pkg::KEY_W-1:0]   key;

  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

### sv/qph_out_if.sv
// Result channel interface: valid/ready plus status and slot.
// Depends on qph_pkg for field widths.
interface qph_out_if;
  logic                          valid;
  logic                          ready;
  logic [qph_pkg::STATUS_W-1:0]  status;
  logic [qph_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

### sv/qph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule

### sv/qph_datapath.sv
// Datapath: key capture, serial home-slot reduction, probe address stepping,
// slot store compare/write, result and output registers. Uses qph_pkg, qph_ram.
module qph_datapath #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qph_pkg::qph_cmd_t             cmd,
  output qph_pkg::qph_sts_t             sts,
  input  logic [qph_pkg::OPC_W-1:0]     in_opcode,
  input  logic [qph_pkg::KEY_W-1:0]     in_key,
  input  logic                          out_ready,
  output logic                          out_valid_r,
  output logic [qph_pkg::STATUS_W-1:0]  out_status_r,
  output logic [qph_pkg::SLOT_W-1:0]    out_slot_r
);
  import qph_pkg::*;

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int RW = SW + HOME_BITS;

  localparam logic [RW-1:0] N1 = RW'(TABLE_SIZE);
  localparam logic [RW-1:0] N2 = RW'(2 * TABLE_SIZE);
  localparam logic [RW-1:0] N3 = RW'(3 * TABLE_SIZE);
  localparam logic [SW:0]   NX = (SW + 1)'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] CNT_N     = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] CNT_LAST  = CW'(TABLE_SIZE - 1);
  localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HOME_STEPS - 1);

  logic [OPC_W-1:0]    op_r;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    ksh_r;
  logic [SW-1:0]       r_r;
  logic [HCNT_W-1:0]   hcnt_r;
  logic [SW-1:0]       x_r;
  logic [SW-1:0]       d_r;
  logic [CW-1:0]       iss_cnt_r;
  logic [CW-1:0]       chk_cnt_r;
  logic                dv_r;
  logic [SW-1:0]       pend_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [SW-1:0]       res_slot_r;
  logic [SW-1:0]       clr_cnt_r;

  logic [RW-1:0]       v;
  logic [SW-1:0]       r_nxt;
  logic [SW:0]         xs;
  logic [SW:0]         ds;
  logic [SW-1:0]       x_nxt;
  logic [SW-1:0]       d_nxt;
  logic                issue;
  logic [KEY_W-1:0]    rd_data;
  logic                key_hit;
  logic                empty;
  logic                wr_ins;
  logic                hit_end;
  logic                exhaust;
  logic                we;
  logic [SW-1:0]       waddr;
  logic [KEY_W-1:0]    wdata;
  logic [SW+SLOT_W-1:0] slot_ext;

  // r = (4r + next two key bits) mod TABLE_SIZE; value stays below 4*TABLE_SIZE
  always_comb begin
    v = {r_r, ksh_r[KEY_W-1 -: HOME_BITS]};
    priority if (v >= N3) begin
      r_nxt = SW'(v - N3);
    end else if (v >= N2) begin
      r_nxt = SW'(v - N2);
    end else if (v >= N1) begin
      r_nxt = SW'(v - N1);
    end else begin
      r_nxt = SW'(v);
    end
  end

  // slot(i+1) = slot(i) + (2i+1) mod N; the odd step itself advances by 2 mod N
  always_comb begin
    xs    = {1'b0, x_r} + {1'b0, d_r};
    ds    = {1'b0, d_r} + (SW + 1)'(2);
    x_nxt = (xs >= NX) ? SW'(xs - NX) : SW'(xs);
    d_nxt = (ds >= NX) ? SW'(ds - NX) : SW'(ds);
  end

  assign issue   = cmd.probe && (iss_cnt_r != CNT_N);
  assign key_hit = dv_r && (rd_data == key_r);
  assign empty   = dv_r && (rd_data == '0);
  assign wr_ins  = cmd.probe && empty && (op_r == OP_INSERT);
  assign hit_end = (op_r == OP_INSERT) ? empty : (key_hit || empty);
  assign exhaust = dv_r && (chk_cnt_r == CNT_LAST);

  assign we    = cmd.clear || wr_ins;
  assign waddr = cmd.clear ? clr_cnt_r : pend_r;
  assign wdata = cmd.clear ? '0 : key_r;

  qph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk       (clk),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (issue),
    .raddr     (x_r),
    .rd_data_r (rd_data)
  );

  always_comb begin
    sts.clear_last = (clr_cnt_r == LAST_SLOT);
    sts.key_zero   = (key_r == '0);
    sts.home_last  = (hcnt_r == HCNT_LAST);
    sts.probe_done = cmd.probe && dv_r && (hit_end || exhaust);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + SW'(1);
      end
      dv_r <= issue;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      key_r  <= in_key;
      ksh_r  <= in_key;
      r_r    <= '0;
      hcnt_r <= '0;
    end
    if (cmd.home_step) begin
      r_r       <= r_nxt;
      ksh_r     <= ksh_r << HOME_BITS;
      hcnt_r    <= hcnt_r + HCNT_W'(1);
      x_r       <= r_nxt;
      d_r       <= SW'(1);
      iss_cnt_r <= '0;
      chk_cnt_r <= '0;
    end
    if (issue) begin
      x_r       <= x_nxt;
      d_r       <= d_nxt;
      iss_cnt_r <= iss_cnt_r + CW'(1);
      pend_r    <= x_r;
    end
    if (cmd.probe && dv_r) begin
      chk_cnt_r <= chk_cnt_r + CW'(1);
      if (hit_end) begin
        res_status_r <= (key_hit || op_r == OP_INSERT) ? ST_OK : ST_NOT_FOUND;
        res_slot_r   <= (key_hit || op_r == OP_INSERT) ? pend_r : '0;
      end else if (exhaust) begin
        res_status_r <= (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        res_slot_r   <= '0;
      end
    end
    if (cmd.zero_res) begin
      res_status_r <= ST_ZERO_KEY;
      res_slot_r   <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[SLOT_W-1:0];
    end
  end

endmodule

### sv/qph_ctrl.sv
// Controller state machine: clear pass, item intake, home reduction, probing, result.
// Uses qph_pkg command/status structs.
module qph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qph_pkg::qph_sts_t sts,
  output qph_pkg::qph_cmd_t cmd
);
  import qph_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HOME   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        if (sts.key_zero) begin
          cmd.zero_res = 1'b1;
          state_nxt    = S_RESULT;
        end else begin
          cmd.home_step = 1'b1;
          if (sts.home_last) begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic-probe hash table: controller plus datapath.
// Depends on qph_pkg, qph_in_if, qph_out_if, qph_ctrl, qph_datapath, qph_ram.
//
// Usage:
//  - in_ch carries one request item (opcode: insert or search, 32-bit key).
//    It is taken on a clock edge with valid and ready both high.
//  - out_ch returns exactly one item per request: status and 4-bit slot
//    (low bits of the slot number; zero unless status is done/found).
//  - Flow: the key is reduced mod TABLE_SIZE two bits per cycle, then one slot
//    is probed per cycle through the single read port of the slot store,
//    whose read data is registered, until a probed slot settles the request
//    or all TABLE_SIZE slots have been checked; a zero key skips both steps.
//  - Items are handled one at a time: the next item is accepted in the cycle
//    after the previous one has moved into the output register, even if the
//    receiver has not taken it yet.
//  - Receiver stall: the result holds in the output register; a finished
//    later result waits inside the block until that register frees up.
//  - Reset (synchronous, active low): a clearing pass writes zero into every
//    slot, with in_ch.ready low until it ends.
module quadratic_probe_hash_table_unit #(
  parameter int TABLE_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qph_in_if.sink    in_ch,
  qph_out_if.source out_ch
);
  import qph_pkg::*;

  qph_cmd_t cmd;
  qph_sts_t sts;

  // sequencing: clear, intake, home reduction, probe, result hand-off
  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot store, probe arithmetic and output register
  qph_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_ch.opcode),
    .in_key       (in_ch.key),
    .out_ready    (out_ch.ready),
    .out_valid_r  (out_ch.valid),
    .out_status_r (out_ch.status),
    .out_slot_r   (out_ch.slot)
  );

endmodule
